// ===== design/dfmm_pkg.sv =====
package dfmm_pkg;
   localparam int unsigned SampleWidth = 32;
   localparam int unsigned DepthWidth = 16;
   localparam int unsigned ProdWidth = 34;
   localparam logic [9:0] MmPerMetre = 10'd1000;
   localparam logic [7:0] ExpAllOnes = 8'hFF;
   localparam logic [7:0] ExpSaturate = 8'd150;
   localparam logic [7:0] ShiftSubnormal = 8'd149;
   localparam logic [7:0] ShiftTooSmall = 8'd35;
   localparam logic [ProdWidth:0] TwiceMax = 35'd131070;
   localparam logic [DepthWidth-1:0] DepthMax = 16'hFFFF;
   localparam logic [DepthWidth-1:0] DepthMin = 16'd1;
   localparam logic ModeRaw = 1'b0;
endpackage

// ===== design/depth_float_to_mm_converter_top.sv =====
// A request passes the input register and then the result register before its response is valid.
// One request per cycle while the response is not stalled; the two-stage pipeline fills bubbles under response stall.
// The path between the registers is one 24x10 constant multiply and a 35-bit right shift.
// Reset (synchronous, active high) clears both stage valids and sets the encoding to raw.
module depth_float_to_mm_converter_top
   import dfmm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic                   csr_depth_encoding,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SampleWidth-1:0] req_sample_bits,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [DepthWidth-1:0]  rsp_distance_mm
);
   logic                   mode_ff;
   logic                   s1_valid_ff;
   logic [SampleWidth-1:0] s1_bits_ff;
   logic                   s2_valid_ff;
   logic [DepthWidth-1:0]  s2_depth_ff;
   logic                   s2_en;
   logic                   s1_en;
   logic [DepthWidth-1:0]  depth_in;

   logic [7:0]             expo;
   logic [23:0]            mant;
   logic [ProdWidth-1:0]   prod;
   logic [7:0]             shift;
   logic [ProdWidth:0]     twice;
   logic [ProdWidth:0]     rounded;

   // advance each stage when it is empty or the next one moves
   assign s2_en = !s2_valid_ff || !rsp_stall;
   assign s1_en = !s1_valid_ff || s2_en;
   assign req_stall = !s1_en;
   assign rsp_valid = s2_valid_ff;
   assign rsp_distance_mm = s2_depth_ff;

   // convert the held request
   always_comb begin
      expo = s1_bits_ff[30:23];
      mant = (expo == 8'd0) ? {1'b0, s1_bits_ff[22:0]} : {1'b1, s1_bits_ff[22:0]};
      prod = ProdWidth'(mant) * ProdWidth'(MmPerMetre);
      shift = (expo == 8'd0) ? ShiftSubnormal : (ExpSaturate - expo);
      twice = '0;
      rounded = '0;
      if (mode_ff == ModeRaw) begin
         depth_in = s1_bits_ff[DepthWidth-1:0];
      end else if (expo == ExpAllOnes || s1_bits_ff[30:0] == 31'd0 || s1_bits_ff[31]) begin
         depth_in = '0;
      end else if (expo >= ExpSaturate) begin
         depth_in = DepthMax;
      end else if (shift > ShiftTooSmall) begin
         depth_in = DepthMin;
      end else begin
         // keep one fraction bit, then round half up
         twice = {1'b0, prod} >> (shift - 8'd1);
         rounded = (twice + 35'd1) >> 1;
         if (twice >= TwiceMax) begin
            depth_in = DepthMax;
         end else if (twice < 35'd2) begin
            depth_in = DepthMin;
         end else begin
            depth_in = rounded[DepthWidth-1:0];
         end
      end
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ModeRaw;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            mode_ff <= csr_depth_encoding;
         end
         if (s1_en) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_bits_ff <= req_sample_bits;
      end
      if (s2_en) begin
         s2_depth_ff <= depth_in;
      end
   end
endmodule
